/* rtl/wrf_pkg.sv */
// ----------------------------------------------------------------------------
// wrf_pkg
// shared constants, codes and types of the windowed rank filter
// ----------------------------------------------------------------------------
package wrf_pkg;

  // default geometry
  localparam int WINDOW_DEF      = 9;
  localparam int SAMPLE_BITS_DEF = 12;

  // rank register
  localparam int             RANK_W     = 4;
  localparam logic [RANK_W-1:0] RANK_RESET = 4'd5;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_RANK = 1'b0;

  // request operation codes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // control shared by all cells of the sort row
  typedef struct packed {
    logic sort_en;  // perform one compare-exchange pass
    logic phase;    // 0: pairs start at even cells, 1: at odd cells
  } cell_ctrl_t;

endpackage

/* rtl/windowed_rank_filter.sv */
// ----------------------------------------------------------------------------
// windowed_rank_filter
// rank-order filter over a store of WINDOW samples kept in a row of sort cells
// ----------------------------------------------------------------------------
// The store is a row of WINDOW cells, one sample each, cleared at reset. A
// store request (operation 0) writes the sample into the cell at the write
// pointer in the cycle it is accepted, so one store request is taken every
// cycle while the filter is idle; the pointer wraps from WINDOW-1 to 0. An
// evaluate request (operation 1) runs WINDOW odd-even transposition passes
// across the cell row, one pass per cycle in which each paired cell
// compare-exchanges with its neighbor, then captures the cell at the
// configured rank into the output register. An evaluate holds off new
// requests from its accept through the WINDOW passes until the capture. The
// sort stays in the store, so later stores overwrite slots of the sorted row.
// A rank of WINDOW or above returns the last (largest) entry. A finished
// result waits in the output register while new requests are accepted; a
// second evaluate holds at capture until the previous result has been taken.
// The rank register sits at byte address 0 of the apb port, reset value 5.
// ----------------------------------------------------------------------------
module windowed_rank_filter #(
  parameter int WINDOW      = wrf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = wrf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            out_ranked_value,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wrf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wrf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wrf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int PTR_W = $clog2(WINDOW);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [PTR_W-1:0]       pass_r;
  logic [PTR_W-1:0]       pass_nxt;
  logic [PTR_W-1:0]       wp_r;
  logic [PTR_W-1:0]       wp_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_val_r;
  logic [SAMPLE_BITS-1:0] out_val_nxt;

  logic                   in_acc;
  logic                   store_acc;
  logic                   eval_acc;
  logic                   capture;
  logic                   last_pass;
  logic [wrf_pkg::RANK_W-1:0] rank;
  logic [31:0]            rank_ext;
  logic [PTR_W-1:0]       pos;
  wrf_pkg::cell_ctrl_t    ctrl;
  logic [SAMPLE_BITS-1:0] cell_val [WINDOW];
  logic                   cells_sorted;

  // rank register
  wrf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rank    (rank)
  );

  // handshake decode
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign store_acc = in_acc && (in_operation == wrf_pkg::OP_STORE);
  assign eval_acc  = in_acc && (in_operation == wrf_pkg::OP_EVAL);
  assign last_pass = (pass_r == PTR_W'(WINDOW - 1));

  // capture once the previous result is gone or leaving now
  assign capture = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // rank beyond the store saturates to the top entry
  assign rank_ext = 32'(rank);
  assign pos      = (rank_ext >= 32'(WINDOW)) ? PTR_W'(WINDOW - 1) : PTR_W'(rank_ext);

  // sort control, phase alternates every pass
  assign ctrl.sort_en = (state_r == ST_SORT);
  assign ctrl.phase   = pass_r[0];

  // the cell row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_val;
    logic [SAMPLE_BITS-1:0] right_val;
    logic                   load;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    assign load = store_acc && (wp_r == PTR_W'(i));

    wrf_cell #(
      .IDX         (i),
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load      (load),
      .sample    (in_sample),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  // sequencer and write pointer
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    wp_nxt    = wp_r;
    case (state_r)
      ST_IDLE: begin
        if (store_acc) begin
          wp_nxt = (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
        end
        if (eval_acc) begin
          state_nxt = ST_SORT;
          pass_nxt  = '0;
        end
      end
      ST_SORT: begin
        if (last_pass) begin
          state_nxt = ST_DONE;
          pass_nxt  = '0;
        end else begin
          pass_nxt = pass_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (capture) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pass_nxt  = '0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (capture) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = cell_val[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ranked_value = out_val_r;

  // row is ascending, used by the checks below
  always_comb begin
    cells_sorted = 1'b1;
    for (int k = 0; k < WINDOW - 1; k++) begin
      if (cell_val[k] > cell_val[k+1]) begin
        cells_sorted = 1'b0;
      end
    end
  end

  // after the last pass the row must be in order
  a_sorted_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> cells_sorted)
    else $error("cell row not sorted after the last pass");

  // a sort runs exactly WINDOW passes
  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT && last_pass) |=> (state_r == ST_DONE))
    else $error("sort did not end after WINDOW passes");

  // write pointer stays inside the store
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_W'(WINDOW - 1))
    else $error("write pointer beyond the store");

  // a capture always presents a result in the next cycle
  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (out_valid && state_r == ST_IDLE))
    else $error("captured result not presented");

endmodule

/* rtl/wrf_cell.sv */
// ----------------------------------------------------------------------------
// wrf_cell
// one slot of the sample store with its compare-exchange against a neighbor
// ----------------------------------------------------------------------------
module wrf_cell #(
  parameter int IDX         = 0,
  parameter int WINDOW      = wrf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = wrf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wrf_pkg::cell_ctrl_t    ctrl,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] left_val,
  input  logic [SAMPLE_BITS-1:0] right_val,
  output logic [SAMPLE_BITS-1:0] val
);

  localparam logic IDX_ODD   = ((IDX % 2) == 1);
  localparam logic HAS_LEFT  = (IDX > 0);
  localparam logic HAS_RIGHT = (IDX < WINDOW - 1);

  logic [SAMPLE_BITS-1:0] val_r;
  logic [SAMPLE_BITS-1:0] val_nxt;
  logic                   low_member;
  logic                   high_member;

  // low member of a pair keeps the minimum, high member the maximum
  assign low_member  = (IDX_ODD == ctrl.phase) && HAS_RIGHT;
  assign high_member = (IDX_ODD != ctrl.phase) && HAS_LEFT;

  always_comb begin
    val_nxt = val_r;
    if (load) begin
      val_nxt = sample;
    end else if (ctrl.sort_en) begin
      if (low_member && (right_val < val_r)) begin
        val_nxt = right_val;
      end else if (high_member && (left_val > val_r)) begin
        val_nxt = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

/* rtl/wrf_cfg.sv */
// ----------------------------------------------------------------------------
// wrf_cfg
// apb register file holding the rank register
// ----------------------------------------------------------------------------
module wrf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wrf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [wrf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [wrf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [wrf_pkg::RANK_W-1:0]          rank
);

  logic [wrf_pkg::RANK_W-1:0] rank_r;
  logic [wrf_pkg::RANK_W-1:0] rank_nxt;
  logic                       sel_rank;

  assign sel_rank = (paddr[2] == wrf_pkg::REG_RANK);
  assign pready   = 1'b1;

  always_comb begin
    rank_nxt = rank_r;
    if (psel && penable && pwrite && sel_rank) begin
      rank_nxt = pwdata[wrf_pkg::RANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= wrf_pkg::RANK_RESET;
    end else begin
      rank_r <= rank_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_rank) begin
      prdata = {{(wrf_pkg::CFG_DATA_W - wrf_pkg::RANK_W){1'b0}}, rank_r};
    end
  end

  assign rank = rank_r;

endmodule
